FILE: sv/aoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoc_pkg
// Shared constants and the pipeline stage type of the alpha-over compositor.
// ----------------------------------------------------------------------------
package aoc_pkg;

    localparam int FIELD_W    = 15;
    localparam int FULL_W     = 16;            // full scale may reach 65535
    localparam int FULL_DEF   = 32640;
    localparam int FIELD_MAX  = 32767;
    localparam int WGT_W      = 32;            // one weight
    localparam int SUM_W      = 33;            // sum of both weights
    localparam int NUM_W      = 49;            // 2*numerator + denominator
    localparam int DEN_W      = 34;            // 2*denominator
    localparam int QUO_W      = 16;            // quotient bits, one per cell
    localparam int LANES      = 4;             // red, green, blue, alpha
    localparam int IN_TDATA_W = 120;
    localparam int OUT_TDATA_W = 64;

    typedef struct packed {
        logic                         vld;
        logic                         zero;
        logic [LANES-1:0][NUM_W-1:0]  rem;
        logic [LANES-1:0][DEN_W-1:0]  den;
        logic [LANES-1:0][QUO_W-1:0]  quo;
    } t_stage;

endpackage

FILE: sv/aoc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoc_front
// Input saturation, weight products and weighted numerators, two stages.
// ----------------------------------------------------------------------------
module aoc_front import aoc_pkg::*; #(
    parameter int FULL_SCALE = FULL_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [IN_TDATA_W-1:0] i_data,
    output t_stage                o_stage
);

    localparam logic [FULL_W-1:0] FULL = FULL_W'(FULL_SCALE);

    logic [7:0][FULL_W-1:0] sat;
    logic [WGT_W-1:0]       near_w, far_w;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            sat[k] = (FULL_W'(i_data[k*FIELD_W +: FIELD_W]) > FULL) ? FULL
                     : FULL_W'(i_data[k*FIELD_W +: FIELD_W]);
        end
        near_w = WGT_W'(sat[3]) * WGT_W'(FULL);
        far_w  = WGT_W'(FULL - sat[3]) * WGT_W'(sat[7]);
    end

    logic                   r_s1_vld;
    logic [2:0][FULL_W-1:0] r_near_c, r_far_c;
    logic [WGT_W-1:0]       r_near_w, r_far_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_near_c <= {sat[2], sat[1], sat[0]};
            r_far_c  <= {sat[6], sat[5], sat[4]};
            r_near_w <= near_w;
            r_far_w  <= far_w;
        end
    end

    logic [SUM_W-1:0] sum_w;
    t_stage           n_stage;

    always_comb begin
        sum_w = SUM_W'(r_near_w) + SUM_W'(r_far_w);
        n_stage.vld  = r_s1_vld;
        n_stage.zero = (sum_w == '0);
        n_stage.quo  = '0;
        for (int c = 0; c < 3; c++) begin
            // Rounded division: (2*num + den) / (2*den).
            n_stage.rem[c] = (NUM_W'(r_near_c[c]) * NUM_W'(r_near_w)
                              + NUM_W'(r_far_c[c]) * NUM_W'(r_far_w)) * NUM_W'(2)
                             + NUM_W'(sum_w);
            n_stage.den[c] = DEN_W'(sum_w) << 1;
        end
        n_stage.rem[3] = (NUM_W'(sum_w) << 1) + NUM_W'(FULL);
        n_stage.den[3] = DEN_W'(FULL) << 1;
        if (n_stage.zero) begin
            // No weight at all: keep the dividers harmless, output is forced.
            for (int c = 0; c < LANES; c++) begin
                n_stage.rem[c] = '0;
                n_stage.den[c] = DEN_W'(2);
            end
        end
    end

    t_stage r_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else if (i_en) begin
            r_stage.vld <= n_stage.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage.zero <= n_stage.zero;
            r_stage.rem  <= n_stage.rem;
            r_stage.den  <= n_stage.den;
            r_stage.quo  <= n_stage.quo;
        end
    end

    assign o_stage = r_stage;

endmodule

FILE: sv/aoc_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoc_div_cell
// One restoring division step on all four lanes, decides one quotient bit.
// ----------------------------------------------------------------------------
module aoc_div_cell import aoc_pkg::*; #(
    parameter int QBIT = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_stage i_stage,
    output t_stage o_stage
);

    t_stage                      n_stage;
    logic [LANES-1:0][NUM_W-1:0] dsh;

    always_comb begin
        n_stage = i_stage;
        for (int c = 0; c < LANES; c++) begin
            dsh[c] = NUM_W'(i_stage.den[c]) << QBIT;
            if (i_stage.rem[c] >= dsh[c]) begin
                n_stage.rem[c]       = i_stage.rem[c] - dsh[c];
                n_stage.quo[c][QBIT] = 1'b1;
            end
        end
    end

    t_stage r_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else if (i_en) begin
            r_stage.vld <= n_stage.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage.zero <= n_stage.zero;
            r_stage.rem  <= n_stage.rem;
            r_stage.den  <= n_stage.den;
            r_stage.quo  <= n_stage.quo;
        end
    end

    assign o_stage = r_stage;

endmodule

FILE: sv/alpha_over_composite_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_over_composite_core
// Porter-Duff over of two straight-alpha colours, one pair per unstalled cycle.
// ----------------------------------------------------------------------------
// The slave channel takes a near and a far colour per transaction; the
// master channel returns the composited colour and a flag that marks a
// pair in which both colours are fully transparent (colour forced to zero).
// An accepted input transaction passes two front stages (weights, then
// numerators) and sixteen divider cells, each deciding one quotient bit
// for all four channels at once. The chain takes one transaction per
// cycle while it is not stalled; the whole chain moves as one.
// The last cell is the output register. When the receiver stalls with a
// result waiting, the chain holds and o_s_tready drops; an empty output
// register lets it keep accepting. Reset clears all valid flags; data
// registers keep their contents and are ignored.
// ----------------------------------------------------------------------------
module alpha_over_composite_core import aoc_pkg::*; #(
    parameter int FULL_SCALE = FULL_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // near_red, near_green, near_blue, near_alpha,
    // far_red, far_green, far_blue, far_alpha (15 bits each)
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // out_red, out_green, out_blue, out_alpha (15 bits each), zero fill
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // both_transparent
    output logic                   o_m_tuser
);

    t_stage stage [QUO_W+1];
    logic   en;

    assign en         = !stage[QUO_W].vld || i_m_tready;
    assign o_s_tready = en;

    aoc_front #(.FULL_SCALE(FULL_SCALE)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_stage (stage[0])
    );

    for (genvar g = 0; g < QUO_W; g++) begin : g_cell
        aoc_div_cell #(.QBIT(QUO_W - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (stage[g]),
            .o_stage (stage[g+1])
        );
    end

    logic [LANES-1:0][FIELD_W-1:0] res;

    always_comb begin
        for (int c = 0; c < LANES; c++) begin
            if (stage[QUO_W].zero) begin
                res[c] = '0;
            end else if (stage[QUO_W].quo[c] > QUO_W'(FIELD_MAX)) begin
                res[c] = FIELD_W'(FIELD_MAX);
            end else begin
                res[c] = stage[QUO_W].quo[c][FIELD_W-1:0];
            end
        end
    end

    assign o_m_tvalid = stage[QUO_W].vld;
    assign o_m_tdata  = {{(OUT_TDATA_W - LANES*FIELD_W){1'b0}}, res};
    assign o_m_tuser  = stage[QUO_W].zero;

endmodule

FILE: tb/tb_alpha_over_composite_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alpha_over_composite_core
// Self-checking bench for the alpha-over compositor.
// ----------------------------------------------------------------------------
// Near and far colour pairs go into the slave channel, first a directed set
// and then random pairs. A compositing function predicts each result. The
// predictions wait in a queue, and the monitor compares every master
// transaction with the oldest one. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_alpha_over_composite_core;
    import aoc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [FIELD_W-1:0] far_alpha, far_blue, far_green, far_red;
        logic [FIELD_W-1:0] near_alpha, near_blue, near_green, near_red;
    } t_pixel_pair;

    typedef struct packed {
        logic               transparent;
        logic [FIELD_W-1:0] alpha, blue, green, red;
    } t_composite;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;

    t_pixel_pair pending_pairs[$];
    t_composite  expected_colours[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    bit          hold_sender = 1'b0;
    bit          stimulus_done = 1'b0;

    alpha_over_composite_core i_dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic longint unsigned clamp_in(logic [FIELD_W-1:0] v);
        return (v > FULL_DEF) ? FULL_DEF : v;
    endfunction

    function automatic longint unsigned round_div(longint unsigned num,
                                                  longint unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic logic [FIELD_W-1:0] clamp_out(longint unsigned v);
        return (v > FIELD_MAX) ? FIELD_W'(FIELD_MAX) : FIELD_W'(v);
    endfunction

    function automatic t_composite composite_over(t_pixel_pair p);
        longint unsigned na, fa, far_w, near_w, sum_w;
        t_composite c;
        na     = clamp_in(p.near_alpha);
        fa     = clamp_in(p.far_alpha);
        far_w  = (FULL_DEF - na) * fa;
        near_w = na * FULL_DEF;
        sum_w  = far_w + near_w;
        c = '0;
        if (sum_w == 0) begin
            c.transparent = 1'b1;
            return c;
        end
        c.red   = clamp_out(round_div(clamp_in(p.near_red) * near_w
                                      + clamp_in(p.far_red) * far_w, sum_w));
        c.green = clamp_out(round_div(clamp_in(p.near_green) * near_w
                                      + clamp_in(p.far_green) * far_w, sum_w));
        c.blue  = clamp_out(round_div(clamp_in(p.near_blue) * near_w
                                      + clamp_in(p.far_blue) * far_w, sum_w));
        c.alpha = clamp_out(round_div(sum_w, FULL_DEF));
        return c;
    endfunction

    // Mostly in range, with the ends of the range and out-of-range codes mixed in.
    function automatic logic [FIELD_W-1:0] random_channel();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return '0;
        if (sel == 1) return FIELD_W'(FULL_DEF);
        if (sel == 2) return FIELD_W'($urandom_range(FULL_DEF + 1, FIELD_MAX));
        if (sel == 3) return FIELD_W'($urandom_range(0, 8));
        return FIELD_W'($urandom_range(0, FULL_DEF));
    endfunction

    function automatic t_pixel_pair random_pair();
        t_pixel_pair p;
        p.near_red   = random_channel();
        p.near_green = random_channel();
        p.near_blue  = random_channel();
        p.near_alpha = random_channel();
        p.far_red    = random_channel();
        p.far_green  = random_channel();
        p.far_blue   = random_channel();
        p.far_alpha  = random_channel();
        return p;
    endfunction

    function automatic int random_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                           : $urandom_range(0, 2);
    endfunction

    function automatic t_pixel_pair uniform_pair(int unsigned n, int unsigned na,
                                                 int unsigned f, int unsigned fa);
        t_pixel_pair p;
        p.near_red   = FIELD_W'(n);
        p.near_green = FIELD_W'(n);
        p.near_blue  = FIELD_W'(n);
        p.near_alpha = FIELD_W'(na);
        p.far_red    = FIELD_W'(f);
        p.far_green  = FIELD_W'(f);
        p.far_blue   = FIELD_W'(f);
        p.far_alpha  = FIELD_W'(fa);
        return p;
    endfunction

    initial begin
        t_pixel_pair p;
        pending_pairs.push_back(uniform_pair(FULL_DEF, 0, FULL_DEF, 0));
        pending_pairs.push_back(uniform_pair(0, 0, 0, 0));
        pending_pairs.push_back(uniform_pair(FIELD_MAX, 0, FIELD_MAX, 0));
        pending_pairs.push_back(uniform_pair(FULL_DEF, FULL_DEF, 0, FULL_DEF));
        pending_pairs.push_back(uniform_pair(0, FULL_DEF, FULL_DEF, FULL_DEF));
        pending_pairs.push_back(uniform_pair(FULL_DEF, 0, 0, FULL_DEF));
        pending_pairs.push_back(uniform_pair(1, 1, 0, 0));
        pending_pairs.push_back(uniform_pair(0, 0, 1, 1));
        pending_pairs.push_back(uniform_pair(1, 1, FULL_DEF, 1));
        pending_pairs.push_back(uniform_pair(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
        pending_pairs.push_back(uniform_pair(FULL_DEF + 1, 16320, 12345, FULL_DEF + 1));
        pending_pairs.push_back(uniform_pair(16320, 16320, 8160, 16320));
        pending_pairs.push_back(uniform_pair(1, FULL_DEF - 1, FULL_DEF - 1, FULL_DEF));
        pending_pairs.push_back(uniform_pair(21845, 10922, 10922, 21845));
        pending_pairs.push_back(uniform_pair(FULL_DEF, 1, 0, FULL_DEF));
        pending_pairs.push_back(uniform_pair(1, 16384, 2, 3));
        pending_pairs.push_back(uniform_pair(FIELD_MAX, FULL_DEF, 0, 0));
        pending_pairs.push_back(uniform_pair(0, FULL_DEF, FIELD_MAX, FIELD_MAX));
        // Walking ones reach every bit of every field; far blue walks a zero instead.
        for (int b = 0; b < FIELD_W; b++) begin
            p = uniform_pair(1 << b, 1 << b, 1 << b, 1 << b);
            p.far_blue = ~p.near_blue;
            pending_pairs.push_back(p);
        end
        for (int k = 0; k < 1150; k++) begin
            pending_pairs.push_back(random_pair());
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: at item 600 it stops until every expected result has come.
    int sent_count = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                expected_colours.push_back(composite_over(t_pixel_pair'(i_s_tdata)));
                sent_count <= sent_count + 1;
                send_gap   <= random_gap();
                if (sent_count + 1 == 600) begin
                    hold_sender <= 1'b1;
                end
            end
            if (i_s_tvalid && !o_s_tready) begin
                // The transaction stays on the bus until it is taken.
            end else if (hold_sender) begin
                i_s_tvalid <= 1'b0;
                if (!i_s_tvalid && expected_colours.size() == 0) begin
                    hold_sender <= 1'b0;
                end
            end else if (send_gap > 0 && !(i_s_tvalid && o_s_tready)) begin
                i_s_tvalid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if ((i_s_tvalid && o_s_tready && random_gap() != 0)
                         || pending_pairs.size() == 0) begin
                i_s_tvalid <= 1'b0;
                if (pending_pairs.size() == 0 && !(i_s_tvalid && !o_s_tready)) begin
                    stimulus_done <= 1'b1;
                end
            end else begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= IN_TDATA_W'(pending_pairs.pop_front());
            end
        end
    end

    // Monitor and receiver-side stalls.
    always @(posedge i_clk) begin
        t_composite got, want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got = '0;
                got.red         = o_m_tdata[0 +: FIELD_W];
                got.green       = o_m_tdata[FIELD_W +: FIELD_W];
                got.blue        = o_m_tdata[2*FIELD_W +: FIELD_W];
                got.alpha       = o_m_tdata[3*FIELD_W +: FIELD_W];
                got.transparent = o_m_tuser;
                if (expected_colours.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    error_count++;
                end else begin
                    want = expected_colours.pop_front();
                    if (got.red !== want.red)
                        $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
                    if (got.green !== want.green)
                        $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
                    if (got.blue !== want.blue)
                        $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
                    if (got.alpha !== want.alpha)
                        $display("%0t: alpha expected %0d actual %0d", $time, want.alpha, got.alpha);
                    if (got.transparent !== want.transparent)
                        $display("%0t: transparent flag expected %0b actual %0b",
                                 $time, want.transparent, got.transparent);
                    if (got !== want) error_count++;
                end
            end
            if (recv_gap > 0) begin
                i_m_tready <= 1'b0;
                recv_gap   <= recv_gap - 1;
            end else if (i_m_tready && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                recv_gap   <= random_gap();
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (stimulus_done && expected_colours.size() == 0 || idle_cycles >= WATCHDOG_LIMIT);
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("*** FAILED ***");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (error_count == 0) begin
                $display("*** PASSED ***");
            end else begin
                $display("*** FAILED ***");
            end
        end
        $finish;
    end

endmodule
